/* sv/fdpq_pkg.sv */
package fdpq_pkg;

  // Operation codes carried on the input side.
  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REM_HIGH = 2'd1,
    KIND_REM_LOW  = 2'd2,
    KIND_PEEK     = 2'd3
  } fdpq_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } fdpq_status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } fdpq_state_t;

  // Capacity register width and reset value.
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

/* sv/fdpq_ram.sv */
module fdpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/fifo_double_ended_priority_queue.sv */
// Double-ended priority queue that keeps up to DEPTH (priority, data) entries in
// arrival order in a single-port-read memory, with a running highest and lowest
// priority. An insert, or any refused operation, finishes in the cycle of its
// input transfer and its result is registered for the next cycle. A peek or a
// removal walks the memory one entry per cycle: the search finds the oldest entry
// at the extreme, and a removal then moves every later entry down by one while
// folding all survivors into the new extreme. The block takes no new input
// transfer while an operation runs or while a result waits that would be
// overwritten. The capacity register (7 bits, reset 64, values above DEPTH act
// as DEPTH) may be written at any time the queue is idle; held entries are kept
// when it drops.
module fifo_double_ended_priority_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic clk,
  input  logic rst_n,

  // Input items: in_tdata = {in_data, in_prio}, in_tuser = kind.
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  input  logic [((PRIO_WIDTH+DATA_WIDTH+7)/8)*8-1:0]        in_tdata,  // in_prio, in_data
  input  logic [1:0]                                        in_tuser,  // kind

  // Results: out_tdata = {is_empty, count, out_prio, out_data}, out_tuser = status.
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [((DATA_WIDTH+PRIO_WIDTH+$clog2(DEPTH+1)+1+7)/8)*8-1:0] out_tdata,
                                                 // out_data, out_prio, count, is_empty
  output logic [1:0]                                        out_tuser, // status

  // Capacity register write.
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [fdpq_pkg::CAP_W-1:0]                        cfg_data
);

  import fdpq_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WW     = (CW > CAP_W) ? CW : CAP_W;
  localparam int MW     = DATA_WIDTH + PRIO_WIDTH;
  localparam int OUT_NB = DATA_WIDTH + PRIO_WIDTH + CW + 1;
  localparam int OUT_W  = ((OUT_NB + 7) / 8) * 8;

  fdpq_state_t            state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [PRIO_WIDTH-1:0]  high_r, high_nxt;
  logic [PRIO_WIDTH-1:0]  low_r, low_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [CW-1:0]          chk_r, chk_nxt;
  fdpq_kind_t             kind_r, kind_nxt;
  logic [PRIO_WIDTH-1:0]  tgt_r, tgt_nxt;
  logic [PRIO_WIDTH-1:0]  acc_r, acc_nxt;

  logic                   out_valid_r;
  fdpq_status_t           out_status_r, out_status_nxt;
  logic [DATA_WIDTH-1:0]  out_data_r, out_data_nxt;
  logic [PRIO_WIDTH-1:0]  out_prio_r, out_prio_nxt;
  logic [CW-1:0]          out_count_r, out_count_nxt;
  logic                   out_load;
  logic                   hold_load;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [MW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [MW-1:0]          ram_rdata;

  logic                   in_xfer;
  fdpq_kind_t             in_kind;
  logic [PRIO_WIDTH-1:0]  in_prio;
  logic [DATA_WIDTH-1:0]  in_data;
  logic [PRIO_WIDTH-1:0]  rd_prio;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [PRIO_WIDTH-1:0]  acc_fold;
  logic                   is_full;
  logic [CW-1:0]          chk_inc;

  // Entry memory, each word holds {data, priority}.
  fdpq_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Port unpacking.
  assign in_kind   = fdpq_kind_t'(in_tuser);
  assign in_prio   = in_tdata[PRIO_WIDTH-1:0];
  assign in_data   = in_tdata[PRIO_WIDTH+DATA_WIDTH-1:PRIO_WIDTH];
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign rd_prio   = ram_rdata[PRIO_WIDTH-1:0];
  assign rd_data   = ram_rdata[MW-1:PRIO_WIDTH];
  assign chk_inc   = chk_r + CW'(1);

  // Full when the count reaches the capacity or the physical depth.
  assign is_full = (WW'(count_r) >= WW'(cap_r)) || (count_r >= CW'(DEPTH));

  // Running extreme over the survivors: minimum for remove-lowest, maximum otherwise.
  always_comb begin
    acc_fold = acc_r;
    if (kind_r == KIND_REM_LOW) begin
      if (rd_prio < acc_r) acc_fold = rd_prio;
    end else begin
      if (rd_prio > acc_r) acc_fold = rd_prio;
    end
  end

  // Sequencer: next state, memory control and result loading.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    chk_nxt        = chk_r;
    kind_nxt       = kind_r;
    tgt_nxt        = tgt_r;
    acc_nxt        = acc_r;
    out_load       = 1'b0;
    hold_load      = 1'b0;
    out_status_nxt = STAT_DONE;
    out_data_nxt   = '0;
    out_prio_nxt   = '0;
    out_count_nxt  = count_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = {in_data, in_prio};
    ram_raddr      = chk_inc[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_xfer) begin
          kind_nxt = in_kind;
          if (in_kind == KIND_INSERT) begin
            out_load = 1'b1;
            if (is_full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              ram_we        = 1'b1;
              count_nxt     = count_r + CW'(1);
              out_count_nxt = count_r + CW'(1);
              if (count_r == '0) begin
                high_nxt = in_prio;
                low_nxt  = in_prio;
              end else begin
                if (in_prio > high_r) high_nxt = in_prio;
                if (in_prio < low_r) low_nxt = in_prio;
              end
            end
          end else if (count_r == '0) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_EMPTY;
          end else begin
            tgt_nxt   = (in_kind == KIND_REM_LOW) ? low_r : high_r;
            acc_nxt   = (in_kind == KIND_REM_LOW) ? high_r : low_r;
            chk_nxt   = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // Read data belongs to entry chk_r; entry chk_r + 1 is being read.
        if (rd_prio == tgt_r) begin
          out_data_nxt = rd_data;
          out_prio_nxt = rd_prio;
          chk_nxt      = chk_inc;
          if (kind_r == KIND_PEEK) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            hold_load = 1'b1;
            state_nxt = ST_SHIFT;
          end
        end else begin
          acc_nxt = acc_fold;
          chk_nxt = chk_inc;
          if (chk_inc == count_r) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_EMPTY;
            state_nxt      = ST_IDLE;
          end
        end
      end

      ST_SHIFT: begin
        out_data_nxt = out_data_r;
        out_prio_nxt = out_prio_r;
        if (chk_r == count_r) begin
          // Every later entry has moved down; commit the new extreme.
          out_load      = 1'b1;
          count_nxt     = count_r - CW'(1);
          out_count_nxt = count_r - CW'(1);
          if (kind_r == KIND_REM_LOW) begin
            low_nxt = acc_r;
          end else begin
            high_nxt = acc_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = chk_r[AW-1:0] - AW'(1);
          ram_wdata = ram_rdata;
          acc_nxt   = acc_fold;
          chk_nxt   = chk_inc;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      high_r      <= '0;
      low_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    chk_r  <= chk_nxt;
    kind_r <= kind_nxt;
    tgt_r  <= tgt_nxt;
    acc_r  <= acc_nxt;
    if (out_load || hold_load) begin
      out_data_r <= out_data_nxt;
      out_prio_r <= out_prio_nxt;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  // Result packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_W'({(out_count_r == '0), out_count_r, out_prio_r, out_data_r});

  // The count never exceeds the memory depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // With entries held, the extremes stay ordered.
  a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (high_r >= low_r))
    else $error("highest below lowest");

  // A removal or peek on a non-empty queue starts the search.
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_kind != KIND_INSERT) && (count_r != '0)) |=> (state_r == ST_SEARCH))
    else $error("search did not start");

  // The end of a shift removes exactly one entry and presents a result.
  a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) && (chk_r == count_r)) |=>
      ((count_r == $past(count_r) - CW'(1)) && out_valid_r))
    else $error("removal did not complete");

  // No new input transfer is taken while a search or shift runs.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEARCH) || (state_r == ST_SHIFT)) |-> !in_tready)
    else $error("input taken while busy");

endmodule

/* dv/tb_fifo_double_ended_priority_queue.sv */
module tb_fifo_double_ended_priority_queue;

  import fdpq_pkg::*;

  // One result as seen on the master side.
  typedef struct {
    fdpq_status_t status;
    logic [31:0]  data;
    logic [7:0]   prio;
    logic [6:0]   count;
    logic         is_empty;
  } dpq_result_t;

  // Keeps its own copy of the queue and capacity, works out the result of each
  // accepted request and compares the block's results with them in order.
  class dpq_scoreboard;
    logic [7:0]  held_prio[$];
    logic [31:0] held_data[$];
    logic [7:0]  highest;
    logic [7:0]  lowest;
    logic [6:0]  capacity = CAP_RESET;
    dpq_result_t awaited_results[$];
    int          errors;

    function void set_capacity(logic [6:0] value);
      capacity = value;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function int held();
      return held_prio.size();
    endfunction

    // Applies one accepted request to the queue copy and stores its result.
    function void note_request(fdpq_kind_t kind, logic [7:0] prio, logic [31:0] data);
      dpq_result_t res;
      int          limit;
      int          pos;
      logic [7:0]  target;
      logic [7:0]  next;
      res.status = STAT_DONE;
      res.data   = '0;
      res.prio   = '0;
      limit      = (capacity > 64) ? 64 : capacity;
      if (kind == KIND_INSERT) begin
        if (held_prio.size() >= limit) begin
          res.status = STAT_FULL;
        end else begin
          if (held_prio.size() == 0) begin
            highest = prio;
            lowest  = prio;
          end else begin
            if (prio > highest) highest = prio;
            if (prio < lowest) lowest = prio;
          end
          held_prio.push_back(prio);
          held_data.push_back(data);
        end
      end else if (held_prio.size() == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        target = (kind == KIND_REM_LOW) ? lowest : highest;
        pos = -1;
        foreach (held_prio[i]) begin
          if (pos < 0 && held_prio[i] == target) pos = i;
        end
        if (pos < 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data = held_data[pos];
          res.prio = held_prio[pos];
          if (kind != KIND_PEEK) begin
            held_prio.delete(pos);
            held_data.delete(pos);
            // Only the extreme just taken is rescanned; the other seeds the scan.
            if (kind == KIND_REM_HIGH) begin
              next = lowest;
              foreach (held_prio[i]) if (held_prio[i] > next) next = held_prio[i];
              highest = next;
            end else begin
              next = highest;
              foreach (held_prio[i]) if (held_prio[i] < next) next = held_prio[i];
              lowest = next;
            end
          end
        end
      end
      res.count    = 7'(held_prio.size());
      res.is_empty = (held_prio.size() == 0);
      awaited_results.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one result transfer with the oldest stored result.
    function void check_response(logic [1:0] status, logic [31:0] data, logic [7:0] prio,
                                 logic [6:0] count, logic is_empty);
      dpq_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no result awaited: status %0h", status);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("out_data", want.data, data);
        check_field("out_prio", 32'(want.prio), 32'(prio));
        check_field("count", 32'(want.count), 32'(count));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // in_prio, in_data
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // out_data, out_prio, count, is_empty
  logic [1:0]  out_tuser;  // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  dpq_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  fifo_double_ended_priority_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is checked against the oldest stored result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_response(out_tuser, out_tdata[31:0], out_tdata[39:32], out_tdata[46:40],
                        out_tdata[47]);
    end
  end

  // Offers one request and waits for its transfer, then maybe idles a while.
  task automatic send_request(fdpq_kind_t kind, logic [7:0] prio, logic [31:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {data, prio};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, prio, data);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes the capacity once every awaited result has come back.
  task automatic write_capacity(logic [6:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(value);
  endtask

  // Mostly clustered priorities so that ties and shared extremes are common.
  function automatic logic [7:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'd100 + 8'($urandom_range(0, 7));
    if (r < 65) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // One random phase at a given capacity and idling mode.
  task automatic run_phase(logic [6:0] cap, int mode, int n_items, bit with_hold);
    int         r;
    fdpq_kind_t kind;
    write_capacity(cap);
    send_idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 8 : 0;
    recv_stall_pct = (mode == 2) ? 52 : (mode == 3) ? 8 : 0;
    if (with_hold) hold_request = 150;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      // Lean towards inserts while the queue is short so removals find entries.
      if (sb.held() < 2 && r < 70) kind = KIND_INSERT;
      else if (r < 45) kind = KIND_INSERT;
      else if (r < 65) kind = KIND_REM_HIGH;
      else if (r < 85) kind = KIND_REM_LOW;
      else kind = KIND_PEEK;
      send_request(kind, pick_prio(), $urandom());
    end
  endtask

  // Main sequence: reset, directed requests, then random phases.
  initial begin
    sb             = new;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_INSERT;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on an empty queue are refused.
    send_request(KIND_REM_HIGH, 8'h00, 32'h0);
    send_request(KIND_REM_LOW, 8'h00, 32'h0);
    send_request(KIND_PEEK, 8'h00, 32'h0);
    // Field extremes, ties at both ends, and the oldest-first rule.
    send_request(KIND_INSERT, 8'h80, 32'h0000_0000);
    send_request(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 8'h00, 32'h5555_5555);
    send_request(KIND_INSERT, 8'hFF, 32'hAAAA_AAAA);
    send_request(KIND_INSERT, 8'h00, 32'h0000_0001);
    send_request(KIND_PEEK, 8'h00, 32'h0);
    send_request(KIND_REM_HIGH, 8'h00, 32'h0);
    send_request(KIND_REM_HIGH, 8'h00, 32'h0);
    send_request(KIND_REM_LOW, 8'h00, 32'h0);
    send_request(KIND_REM_LOW, 8'h00, 32'h0);
    // Removing the last entry, then an insert into the emptied queue.
    send_request(KIND_REM_LOW, 8'h00, 32'h0);
    send_request(KIND_INSERT, 8'h07, 32'h1234_5678);
    send_request(KIND_REM_HIGH, 8'h00, 32'h0);
    // A full queue refuses inserts.
    write_capacity(7'd2);
    send_request(KIND_INSERT, 8'h10, 32'hDEAD_BEEF);
    send_request(KIND_INSERT, 8'h20, 32'hCAFE_F00D);
    send_request(KIND_INSERT, 8'h30, 32'h0BAD_F00D);
    // Capacity lowered below the held count keeps the entries.
    write_capacity(7'd1);
    send_request(KIND_INSERT, 8'h40, 32'h1111_1111);
    send_request(KIND_REM_LOW, 8'h00, 32'h0);
    send_request(KIND_INSERT, 8'h50, 32'h2222_2222);
    // Zero capacity refuses every insert.
    write_capacity(7'd0);
    send_request(KIND_REM_HIGH, 8'h00, 32'h0);
    send_request(KIND_INSERT, 8'h60, 32'h3333_3333);

    // Random phases; capacities above the depth act as the depth.
    run_phase(7'd64, 0, 54, 1'b0);
    run_phase(7'd8, 1, 54, 1'b0);
    run_phase(7'd1, 2, 54, 1'b0);
    run_phase(7'd127, 3, 54, 1'b0);
    run_phase(7'd5, 0, 54, 1'b1);
    run_phase(7'd40, 1, 54, 1'b0);
    run_phase(7'd2, 2, 54, 1'b0);
    run_phase(7'd64, 3, 54, 1'b0);

    // Drain and let the block settle before the verdict.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
